### rtl/lkv_cache_pkg.sv
`timescale 1ns / 1ps

package lkv_cache_pkg;

    // Number of physical entries in the store.
    localparam int CAPACITY = 16;

    // Index into the store and a count that can also hold CAPACITY itself.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Field widths fixed by the interface.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;

    // Width wide enough to compare the capacity register against CAPACITY.
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Reset value of the capacity register.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Value returned by a lookup that misses.
    localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

    // Command codes.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // One input word.
    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } out_word_t;

    // Result offered by the sequencer to the output register.
    typedef struct packed {
        logic      valid;
        out_word_t word;
    } res_t;

    // Access to the key and value memories, which share their addresses.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wkey;
        logic [VAL_W-1:0] wval;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

### rtl/lkv_ram.sv
`timescale 1ns / 1ps

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/lkv_seq.sv
`timescale 1ns / 1ps

module lkv_seq (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  lkv_cache_pkg::in_word_t                in_data,
    input  logic [lkv_cache_pkg::CFG_W-1:0]        capacity,
    output lkv_cache_pkg::ram_req_t                ram_req,
    input  logic [lkv_cache_pkg::KEY_W-1:0]        key_rdata,
    input  logic [lkv_cache_pkg::VAL_W-1:0]        val_rdata,
    output lkv_cache_pkg::res_t                    res,
    input  logic                                   res_ready
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SRCH_RD = 8'b0000_0010,
        ST_SRCH_CMP = 8'b0000_0100,
        ST_DECIDE  = 8'b0000_1000,
        ST_SHIFT_RD = 8'b0001_0000,
        ST_SHIFT_WR = 8'b0010_0000,
        ST_HEAD    = 8'b0100_0000,
        ST_RESULT  = 8'b1000_0000
    } state_t;

    localparam int CNT_W = lkv_cache_pkg::CNT_W;
    localparam int IDX_W = lkv_cache_pkg::IDX_W;
    localparam int CMP_W = lkv_cache_pkg::CMP_W;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                occ_reg, occ_next;
    logic                            hit_reg, hit_next;
    logic [CNT_W-1:0]                pos_reg, pos_next;
    logic                            cmd_reg, cmd_next;
    logic [lkv_cache_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lkv_cache_pkg::VAL_W-1:0] val_reg, val_next;
    logic [lkv_cache_pkg::VAL_W-1:0] hitval_reg, hitval_next;

    logic [CMP_W-1:0] cfg_ext;
    logic [CMP_W-1:0] cap_ext;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] keep;
    logic [CNT_W-1:0] top;
    logic [CNT_W-1:0] idx_m1;
    logic             key_match;

    // Effective capacity: zero acts as one, and it saturates at the store size.
    assign cfg_ext = CMP_W'(capacity);
    assign cap_ext = (cfg_ext == '0) ? CMP_W'(1) :
                     (cfg_ext > CMP_W'(lkv_cache_pkg::CAPACITY)) ?
                     CMP_W'(lkv_cache_pkg::CAPACITY) : cfg_ext;
    assign cap     = cap_ext[CNT_W-1:0];

    // Entries kept below the new head when a put inserts an absent key.
    assign keep = (occ_reg >= cap) ? (cap - CNT_W'(1)) : occ_reg;
    assign top  = hit_reg ? pos_reg : keep;

    // The shared key comparator used at every search step.
    assign key_match = (key_rdata == key_reg);

    assign idx_m1 = idx_reg - CNT_W'(1);

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        occ_next    = occ_reg;
        hit_next    = hit_reg;
        pos_next    = pos_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        hitval_next = hitval_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg[IDX_W-1:0];
        ram_req.wkey  = key_rdata;
        ram_req.wval  = val_rdata;
        ram_req.raddr = idx_reg[IDX_W-1:0];

        res.valid           = 1'b0;
        res.word.found      = hit_reg;
        res.word.read_value = hit_reg ? hitval_reg : lkv_cache_pkg::MISS_VALUE;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = in_data.command;
                    key_next   = in_data.key;
                    val_next   = in_data.value;
                    hit_next   = 1'b0;
                    idx_next   = '0;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                // Issue the read of the next held entry, or stop at the end.
                if (idx_reg == occ_reg)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP:
            begin
                if (key_match)
                begin
                    hit_next    = 1'b1;
                    pos_next    = idx_reg;
                    hitval_next = val_rdata;
                    state_next  = ST_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_DECIDE:
            begin
                if (cmd_reg == lkv_cache_pkg::CMD_GET && !hit_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    if (!hit_reg)
                    begin
                        occ_next = keep + CNT_W'(1);
                    end
                    idx_next   = top;
                    state_next = (top == '0) ? ST_HEAD : ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                // Read the entry one place nearer the head.
                ram_req.raddr = idx_m1[IDX_W-1:0];
                state_next    = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                // Move it down one place toward least recent.
                ram_req.we = 1'b1;
                idx_next   = idx_m1;
                state_next = (idx_m1 == '0) ? ST_HEAD : ST_SHIFT_RD;
            end
            ST_HEAD:
            begin
                // The addressed key becomes most recent.
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wkey  = key_reg;
                ram_req.wval  = (cmd_reg == lkv_cache_pkg::CMD_PUT) ? val_reg : hitval_reg;
                state_next    = (cmd_reg == lkv_cache_pkg::CMD_GET) ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            occ_reg   <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
        end
    end

    // Payload held for the word in progress.
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        hitval_reg <= hitval_next;
    end

endmodule

### rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// A word is searched from the head, one held entry at a time, until its key matches or the
// held entries run out; then come a decision step, a move of each more recent entry one place
// toward least recent, a head write, and for a get a result (a lookup miss goes from decision
// straight to result). Words are handled one at a time, via the single read port of the entry
// memory; the next word is taken in idle, and a waiting result holds off the input.
// Reset clears control state, occupancy to empty and capacity to 16; no clearing pass.
module lru_key_value_cache (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  lkv_cache_pkg::in_word_t         in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output lkv_cache_pkg::out_word_t        out_data,
    input  logic                            cfg_we,
    input  logic [lkv_cache_pkg::CFG_W-1:0] cfg_wdata
);

    logic [lkv_cache_pkg::CFG_W-1:0] cap_reg;
    logic                            out_valid_reg;
    lkv_cache_pkg::out_word_t        out_data_reg;
    lkv_cache_pkg::ram_req_t         ram_req;
    lkv_cache_pkg::res_t             res;
    logic [lkv_cache_pkg::KEY_W-1:0] key_rdata;
    logic [lkv_cache_pkg::VAL_W-1:0] val_rdata;
    logic                            res_ready;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkv_cache_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    lkv_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .capacity  (cap_reg),
        .ram_req   (ram_req),
        .key_rdata (key_rdata),
        .val_rdata (val_rdata),
        .res       (res),
        .res_ready (res_ready)
    );

    lkv_ram #(
        .WIDTH (lkv_cache_pkg::KEY_W),
        .DEPTH (lkv_cache_pkg::CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wkey),
        .raddr (ram_req.raddr),
        .rdata (key_rdata)
    );

    lkv_ram #(
        .WIDTH (lkv_cache_pkg::VAL_W),
        .DEPTH (lkv_cache_pkg::CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wval),
        .raddr (ram_req.raddr),
        .rdata (val_rdata)
    );

    // Output register; it frees the sequencer while a result waits.
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            out_data_reg <= res.word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
